// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define LBS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// consequence checked on the clock after the antecedent
`define LBS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/lbs_pkg.sv =====
// types and constants of the led blink sequencer
package lbs_pkg;

   localparam int NUM_LEDS_DEFAULT = 8;
   localparam int PRESCALE_DEFAULT = 12;

   localparam int LED_LINES_W = 8;
   localparam int PROG_W      = 8;
   localparam int INDEX_W     = 3;
   localparam int PRESCALE_W  = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [PROG_W-1:0] PROG_ON  = 8'hFF;
   localparam logic [PROG_W-1:0] PROG_OFF = 8'h00;

   localparam logic [CSR_DATA_W-1:0] ENABLE_MASK_RESET = 8'h00;
   localparam logic [CSR_DATA_W-1:0] COUNT_MASK_RESET  = 8'h7F;
   localparam logic [CSR_DATA_W-1:0] END_ON_MASK_RESET = 8'h80;

   localparam logic MODE_TICK  = 1'b0;
   localparam logic MODE_WRITE = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ENABLE_MASK = 2'd0,
      CSR_COUNT_MASK  = 2'd1,
      CSR_END_ON_MASK = 2'd2
   } lbs_csr_index_type;

   // shared controls handed to every led cell
   typedef struct packed {
      logic              act_tick;
      logic [PROG_W-1:0] count_mask;
      logic [PROG_W-1:0] end_on_mask;
   } lbs_cell_ctrl_type;

endpackage

// ===== hw/rtl/lbs_if.sv =====
// valid/ready channels of the led blink sequencer
interface lbs_req_if;
   import lbs_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 mode;
   logic [INDEX_W-1:0]   led_index;
   logic [PROG_W-1:0]    program_value;

   modport source (output valid, output mode, output led_index, output program_value,
                   input ready);
   modport sink   (input valid, input mode, input led_index, input program_value,
                   output ready);
endinterface

interface lbs_rsp_if;
   import lbs_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [LED_LINES_W-1:0] led_lines;

   modport source (output valid, output led_lines, input ready);
   modport sink   (input valid, input led_lines, output ready);
endinterface

// ===== hw/rtl/led_blink_sequencer_unit.sv =====
// led blink sequencer: eight led lines driven by ticks and per-led programs
//
// Each req beat is a timer tick (mode 0) or a program write for one led (mode 1); each
// one yields exactly one rsp beat carrying the led line levels after it. One beat is
// taken every clock cycle unless rsp back-pressure stalls it; an accepted beat passes
// through the input register and then the result register, with all leds updated in
// parallel by their own cells in between. Only every PRESCALE-th tick acts on the leds;
// program writes do not count as ticks and leave the lines unchanged. On an acting tick
// an enabled led with program 0xFF lights, with 0x00 goes dark, and with any other
// program blinks: a lit line goes dark, a dark one bumps its counter and lights while
// the count is within the count field, then either latches on (end-on flag set, program
// becomes 0xFF) or stays dark. Writing enable_mask darkens leds that are now disabled.
// The user must write configuration via the csr port only while idle (not enforced).
module led_blink_sequencer_unit
   import lbs_pkg::*;
#(
   parameter int NUM_LEDS = NUM_LEDS_DEFAULT,
   parameter int PRESCALE = PRESCALE_DEFAULT
)(
   input  logic                   clock,
   input  logic                   reset,
   lbs_req_if.sink                req,
   lbs_rsp_if.source              rsp,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   `include "assert_macros.svh"

   // configuration registers
   logic [CSR_DATA_W-1:0] enable_mask_ff;
   logic [CSR_DATA_W-1:0] count_mask_ff;
   logic [CSR_DATA_W-1:0] end_on_mask_ff;

   // input register
   logic               s1_valid_ff;
   logic               s1_mode_ff;
   logic [INDEX_W-1:0] s1_index_ff;
   logic [PROG_W-1:0]  s1_program_ff;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [LED_LINES_W-1:0] rsp_lines_ff;

   logic [PRESCALE_W-1:0] prescaler_ff, prescaler_in;

   logic                   req_take;
   logic                   step;
   logic                   tick_wrap;
   logic                   enable_write;
   lbs_cell_ctrl_type      cell_ctrl;
   logic [LED_LINES_W-1:0] lines_in;
   logic [LED_LINES_W-1:0] lines_cur;

   // step: the beat in the input register moves into the result register
   assign step     = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !s1_valid_ff || step;
   assign req_take = req.valid && req.ready;

   // tick acts when the prescaler would reach PRESCALE
   assign tick_wrap = ({1'b0, prescaler_ff} + 5'd1) >= 5'(PRESCALE);

   always_comb begin
      prescaler_in = prescaler_ff;
      if (step && s1_mode_ff == MODE_TICK) begin
         prescaler_in = tick_wrap ? '0 : prescaler_ff + 4'd1;
      end
   end

   assign cell_ctrl.act_tick    = step && (s1_mode_ff == MODE_TICK) && tick_wrap;
   assign cell_ctrl.count_mask  = count_mask_ff;
   assign cell_ctrl.end_on_mask = end_on_mask_ff;

   assign enable_write = csr_write_enable && (csr_index == CSR_ENABLE_MASK);

   // one cell per led; lines past NUM_LEDS stay low
   for (genvar i = 0; i < LED_LINES_W; i++) begin : g_led
      if (i < NUM_LEDS) begin : g_cell
         lbs_led_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (cell_ctrl),
            .enable      (enable_mask_ff[i]),
            .write_sel   (step && (s1_mode_ff == MODE_WRITE) && (s1_index_ff == INDEX_W'(i))),
            .write_value (s1_program_ff),
            .clear_line  (enable_write && !csr_write_data[i]),
            .line_in     (lines_in[i]),
            .line_out    (lines_cur[i])
         );
      end else begin : g_none
         assign lines_in[i]  = 1'b0;
         assign lines_cur[i] = 1'b0;
      end
   end

   // configuration writes; an unused index is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_mask_ff <= ENABLE_MASK_RESET;
         count_mask_ff  <= COUNT_MASK_RESET;
         end_on_mask_ff <= END_ON_MASK_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ENABLE_MASK: enable_mask_ff <= csr_write_data;
            CSR_COUNT_MASK:  count_mask_ff  <= csr_write_data;
            CSR_END_ON_MASK: end_on_mask_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // input register control and prescaler
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         prescaler_ff <= '0;
      end else begin
         prescaler_ff <= prescaler_in;
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (step) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   // input payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_mode_ff    <= req.mode;
         s1_index_ff   <= req.led_index;
         s1_program_ff <= req.program_value;
      end
   end

   // result register: holds until the rsp beat is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_lines_ff <= lines_in;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.led_lines = rsp_lines_ff;

   // a disabled led never has a lit line
   `LBS_ASSERT(a_disabled_dark, (lines_cur & ~enable_mask_ff) == '0, "disabled led line lit")
   // prescaler stays within its period
   `LBS_ASSERT(a_prescaler_range, {1'b0, prescaler_ff} < 5'(PRESCALE), "prescaler out of range")
   // a waiting beat with a free result register becomes a result next cycle
   `LBS_ASSERT_NEXT(a_beat_moves, s1_valid_ff && !rsp_valid_ff, rsp_valid_ff, "beat not moved")

endmodule

// ===== hw/rtl/lbs_led_cell.sv =====
// program, blink counter and line level of one led
module lbs_led_cell
   import lbs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  lbs_cell_ctrl_type ctrl,
   input  logic              enable,
   input  logic              write_sel,
   input  logic [PROG_W-1:0] write_value,
   input  logic              clear_line,
   output logic              line_in,
   output logic              line_out
);

   logic [PROG_W-1:0] program_ff, program_in;
   logic [PROG_W-1:0] counter_ff, counter_in;
   logic              line_ff;
   logic [PROG_W-1:0] counter_inc;

   assign counter_inc = counter_ff + 8'd1;

   always_comb begin
      program_in = program_ff;
      counter_in = counter_ff;
      line_in    = line_ff;
      if (write_sel) begin
         program_in = write_value;
         counter_in = '0;
      end else if (ctrl.act_tick && enable) begin
         if (program_ff == PROG_ON) begin
            line_in = 1'b1;
         end else if (program_ff == PROG_OFF) begin
            line_in = 1'b0;
         end else if (line_ff) begin
            line_in = 1'b0;
         end else begin
            counter_in = counter_inc;
            if (counter_inc <= (program_ff & ctrl.count_mask)) begin
               line_in = 1'b1;
            end else if ((program_ff & ctrl.end_on_mask) != '0) begin
               line_in    = 1'b1;
               program_in = PROG_ON;
            end
         end
      end
      // disabling an led drops its line
      if (clear_line) begin
         line_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         program_ff <= PROG_OFF;
         counter_ff <= '0;
         line_ff    <= 1'b0;
      end else begin
         program_ff <= program_in;
         counter_ff <= counter_in;
         line_ff    <= line_in;
      end
   end

   assign line_out = line_ff;

endmodule
